// File: hw/rtl/ssl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_pkg
// shared types, token codes, scan modes and keyword table for the lexer
// ----------------------------------------------------------------------------
package ssl_pkg;

	localparam int MAX_SOURCE_BYTES_DEF = 65536;
	localparam logic [15:0] FIRST_LINE_RST = 16'd1;

	// token kinds
	localparam logic [5:0] K_LPAREN  = 6'd0;
	localparam logic [5:0] K_RPAREN  = 6'd1;
	localparam logic [5:0] K_LBRACE  = 6'd2;
	localparam logic [5:0] K_RBRACE  = 6'd3;
	localparam logic [5:0] K_COMMA   = 6'd4;
	localparam logic [5:0] K_DOT     = 6'd5;
	localparam logic [5:0] K_MINUS   = 6'd6;
	localparam logic [5:0] K_PLUS    = 6'd7;
	localparam logic [5:0] K_SEMI    = 6'd8;
	localparam logic [5:0] K_SLASH   = 6'd9;
	localparam logic [5:0] K_STAR    = 6'd10;
	localparam logic [5:0] K_BANG    = 6'd11;
	localparam logic [5:0] K_EQUAL   = 6'd13;
	localparam logic [5:0] K_GREATER = 6'd15;
	localparam logic [5:0] K_LESS    = 6'd17;
	localparam logic [5:0] K_IDENT   = 6'd19;
	localparam logic [5:0] K_STRING  = 6'd20;
	localparam logic [5:0] K_NUMBER  = 6'd21;
	localparam logic [5:0] K_KEY0    = 6'd22;
	localparam logic [5:0] K_BAD     = 6'd38;
	localparam logic [5:0] K_UNTERM  = 6'd39;

	// scan modes
	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_BANG    = 4'd1;
	localparam logic [3:0] M_EQ      = 4'd2;
	localparam logic [3:0] M_LT      = 4'd3;
	localparam logic [3:0] M_GT      = 4'd4;
	localparam logic [3:0] M_SLASH   = 4'd5;
	localparam logic [3:0] M_COMMENT = 4'd6;
	localparam logic [3:0] M_STRING  = 4'd7;
	localparam logic [3:0] M_IDENT   = 4'd8;
	localparam logic [3:0] M_INT     = 4'd9;
	localparam logic [3:0] M_FRAC    = 4'd10;

	localparam int PFX_DEPTH = 6;
	localparam int KW_COUNT  = 16;

	// reserved words, byte-reversed so that char 0 sits in the low byte
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		48'("dna"), 48'("ssalc"), 48'("esle"), 48'("eslaf"),
		48'("rof"), 48'("nuf"), 48'("fi"), 48'("lin"), 48'("ro"),
		48'("tnirp"), 48'("nruter"), 48'("repus"),
		48'("siht"), 48'("eurt"), 48'("rav"), 48'("elihw")
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
		3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
	} token_t;

	// tokens caused by one byte: a is always present, b when has_b
	typedef struct packed {
		logic   has_b;
		token_t a;
		token_t b;
	} pair_t;

	typedef struct packed {
		logic  valid;
		pair_t pair;
	} push_t;

	// lexeme length from start to end offset, at least 1, saturating
	function automatic logic [15:0] tok_len(input logic [15:0] ts, input logic [17:0] end_p);
		logic [17:0] d;
		d = end_p - {2'b00, ts};
		if (end_p <= {2'b00, ts})
			return 16'd1;
		else if (d > 18'd65535)
			return 16'hFFFF;
		else
			return d[15:0];
	endfunction

endpackage

// File: hw/rtl/script_source_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_source_lexer
// streaming tokenizer: source bytes in, tokens (kind, offset, length, line) out
// ----------------------------------------------------------------------------
// a token is registered in the pair queue before it is offered on m_axis
// throughput: one byte per cycle while tokens are taken; a byte that causes
//   two tokens sends them one after the other through the single token port
// a two-entry queue of token pairs sits between scan logic and output
// reset: arst_n clears scan state, queue and first_line (to 1) at once
// ----------------------------------------------------------------------------
module script_source_lexer #(
	parameter int MAX_SOURCE_BYTES = ssl_pkg::MAX_SOURCE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// source bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // ch
	input  logic        s_axis_tlast,   // last_byte
	// tokens
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // start_pos, token_len, line_num
	output logic [5:0]  m_axis_tuser,   // token_kind
	output logic        m_axis_tlast,   // last_of_run
	// first_line register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic            room;
	logic            acc;
	logic [15:0]     first_line_q;
	ssl_pkg::push_t  push;
	ssl_pkg::token_t tok;

	// a byte is taken only when both possible tokens fit in the queue
	assign s_axis_tready = room;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// config is always writable; it only matters at the end of a source
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			first_line_q <= ssl_pkg::FIRST_LINE_RST;
		else if (cfg_valid)
			first_line_q <= cfg_data;
	end

	// scan state, prefix buffer and token building
	ssl_scan #(
		.MAX_SOURCE_BYTES (MAX_SOURCE_BYTES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.ch         (s_axis_tdata),
		.last_byte  (s_axis_tlast),
		.first_line (first_line_q),
		.push       (push)
	);

	// token queue; the second token of a pair follows on the next handshake
	ssl_tok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tok   (tok),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {tok.line, tok.len, tok.start};
	assign m_axis_tuser = tok.kind;

endmodule

// File: hw/rtl/ssl_kw.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_kw
// reserved word match on the identifier prefix buffer
// ----------------------------------------------------------------------------
module ssl_kw (
	input  logic [5:0][7:0] pfx,
	input  logic [2:0]      plen,
	output logic [5:0]      kind
);

	always_comb begin
		logic hit;
		logic found;
		found = 1'b0;
		kind  = ssl_pkg::K_IDENT;
		for (int k = 0; k < ssl_pkg::KW_COUNT; k++) begin
			hit = (ssl_pkg::KW_LEN[k] == plen);
			for (int i = 0; i < ssl_pkg::PFX_DEPTH; i++) begin
				if ((3'(i) < plen) && (pfx[i] != ssl_pkg::KW_TEXT[k][8*i +: 8]))
					hit = 1'b0;
			end
			if (hit && !found) begin
				kind  = 6'(ssl_pkg::K_KEY0 + 6'(k));
				found = 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/ssl_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_scan
// scan state and single-pass token generation for one source byte
// ----------------------------------------------------------------------------
module ssl_scan #(
	parameter int MAX_SOURCE_BYTES = ssl_pkg::MAX_SOURCE_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  logic [7:0]      ch,
	input  logic            last_byte,
	input  logic [15:0]     first_line,
	output ssl_pkg::push_t  push
);

	localparam logic [16:0] POS_CAP = (MAX_SOURCE_BYTES < 131071) ?
		17'(MAX_SOURCE_BYTES) : 17'd131071;

	localparam logic [7:0] C_LPAREN = 8'h28;
	localparam logic [7:0] C_RPAREN = 8'h29;
	localparam logic [7:0] C_LBRACE = 8'h7B;
	localparam logic [7:0] C_RBRACE = 8'h7D;
	localparam logic [7:0] C_COMMA  = 8'h2C;
	localparam logic [7:0] C_DOT    = 8'h2E;
	localparam logic [7:0] C_MINUS  = 8'h2D;
	localparam logic [7:0] C_PLUS   = 8'h2B;
	localparam logic [7:0] C_SEMI   = 8'h3B;
	localparam logic [7:0] C_STAR   = 8'h2A;
	localparam logic [7:0] C_BANG   = 8'h21;
	localparam logic [7:0] C_EQ     = 8'h3D;
	localparam logic [7:0] C_LT     = 8'h3C;
	localparam logic [7:0] C_GT     = 8'h3E;
	localparam logic [7:0] C_SLASH  = 8'h2F;
	localparam logic [7:0] C_QUOTE  = 8'h22;
	localparam logic [7:0] C_NL     = 8'h0A;
	localparam logic [7:0] C_CR     = 8'h0D;
	localparam logic [7:0] C_SPACE  = 8'h20;
	localparam logic [7:0] C_TAB    = 8'h09;

	logic [3:0]      mode_q;
	logic [15:0]     tstart_q;
	logic [16:0]     pos_q;
	logic [15:0]     line_q;
	logic [5:0][7:0] pfx_q;
	logic [2:0]      plen_q;

	logic [5:0][7:0] pfx_n;
	logic [2:0]      plen_n;
	logic [5:0]      kw_kind;

	logic            is_alpha;
	logic            is_digit;
	logic [17:0]     pos_p1;
	logic [15:0]     pos_sat;

	logic            a_v;
	logic [5:0]      a_kind;
	logic [17:0]     a_end;
	logic            b_v;
	logic [5:0]      b_kind;
	logic [3:0]      mode2;
	logic [15:0]     ts2;
	logic [15:0]     line2;

	assign is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
	assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
	assign pos_p1   = {1'b0, pos_q} + 18'd1;
	assign pos_sat  = (pos_q > 17'd65535) ? 16'hFFFF : pos_q[15:0];

	// prefix buffer update: continue an identifier or begin a new one
	always_comb begin
		pfx_n  = pfx_q;
		plen_n = plen_q;
		if (is_alpha) begin
			if (mode_q == ssl_pkg::M_IDENT) begin
				if (plen_q < 3'd6)
					pfx_n[plen_q] = ch;
				if (plen_q < 3'd7)
					plen_n = plen_q + 3'd1;
			end else if (mode_q != ssl_pkg::M_COMMENT && mode_q != ssl_pkg::M_STRING) begin
				pfx_n[0] = ch;
				plen_n   = 3'd1;
			end
		end
	end

	ssl_kw u_kw (
		.pfx  (pfx_n),
		.plen (plen_n),
		.kind (kw_kind)
	);

	always_comb begin
		logic       rescan;
		logic [3:0] mode1;
		logic [5:0] op;
		rescan = 1'b0;
		mode1  = mode_q;
		a_v    = 1'b0;
		a_kind = ssl_pkg::K_BAD;
		a_end  = pos_p1;
		b_v    = 1'b0;
		b_kind = ssl_pkg::K_BAD;
		ts2    = tstart_q;
		line2  = line_q;

		unique case (mode_q)
			ssl_pkg::M_BANG:  op = ssl_pkg::K_BANG;
			ssl_pkg::M_EQ:    op = ssl_pkg::K_EQUAL;
			ssl_pkg::M_LT:    op = ssl_pkg::K_LESS;
			default:          op = ssl_pkg::K_GREATER;
		endcase

		// terminate or continue the pending token
		unique case (mode_q)
			ssl_pkg::M_BANG, ssl_pkg::M_EQ, ssl_pkg::M_LT, ssl_pkg::M_GT: begin
				a_v   = 1'b1;
				mode1 = ssl_pkg::M_IDLE;
				if (ch == C_EQ) begin
					a_kind = op + 6'd1;
				end else begin
					a_kind = op;
					a_end  = {1'b0, pos_q};
					rescan = 1'b1;
				end
			end
			ssl_pkg::M_SLASH: begin
				if (ch == C_SLASH) begin
					mode1 = ssl_pkg::M_COMMENT;
				end else begin
					a_v    = 1'b1;
					a_kind = ssl_pkg::K_SLASH;
					a_end  = {1'b0, pos_q};
					mode1  = ssl_pkg::M_IDLE;
					rescan = 1'b1;
				end
			end
			ssl_pkg::M_COMMENT: begin
				if (ch == C_NL) begin
					mode1  = ssl_pkg::M_IDLE;
					rescan = 1'b1;
				end
			end
			ssl_pkg::M_STRING: begin
				if (ch == C_QUOTE) begin
					a_v    = 1'b1;
					a_kind = ssl_pkg::K_STRING;
					mode1  = ssl_pkg::M_IDLE;
				end
			end
			ssl_pkg::M_IDENT: begin
				if (!is_alpha) begin
					a_v    = 1'b1;
					a_kind = kw_kind;
					a_end  = {1'b0, pos_q};
					mode1  = ssl_pkg::M_IDLE;
					rescan = 1'b1;
				end
			end
			ssl_pkg::M_INT: begin
				if (ch == C_DOT) begin
					mode1 = ssl_pkg::M_FRAC;
				end else if (!is_digit) begin
					a_v    = 1'b1;
					a_kind = ssl_pkg::K_NUMBER;
					a_end  = {1'b0, pos_q};
					mode1  = ssl_pkg::M_IDLE;
					rescan = 1'b1;
				end
			end
			ssl_pkg::M_FRAC: begin
				if (!is_digit) begin
					a_v    = 1'b1;
					a_kind = ssl_pkg::K_NUMBER;
					a_end  = {1'b0, pos_q};
					mode1  = ssl_pkg::M_IDLE;
					rescan = 1'b1;
				end
			end
			default: begin
				mode1  = ssl_pkg::M_IDLE;
				rescan = 1'b1;
			end
		endcase

		// scan the byte again from idle
		mode2 = mode1;
		if (rescan) begin
			unique case (ch)
				C_LPAREN: begin b_v = 1'b1; b_kind = ssl_pkg::K_LPAREN; end
				C_RPAREN: begin b_v = 1'b1; b_kind = ssl_pkg::K_RPAREN; end
				C_LBRACE: begin b_v = 1'b1; b_kind = ssl_pkg::K_LBRACE; end
				C_RBRACE: begin b_v = 1'b1; b_kind = ssl_pkg::K_RBRACE; end
				C_COMMA:  begin b_v = 1'b1; b_kind = ssl_pkg::K_COMMA; end
				C_DOT:    begin b_v = 1'b1; b_kind = ssl_pkg::K_DOT; end
				C_MINUS:  begin b_v = 1'b1; b_kind = ssl_pkg::K_MINUS; end
				C_PLUS:   begin b_v = 1'b1; b_kind = ssl_pkg::K_PLUS; end
				C_SEMI:   begin b_v = 1'b1; b_kind = ssl_pkg::K_SEMI; end
				C_STAR:   begin b_v = 1'b1; b_kind = ssl_pkg::K_STAR; end
				C_BANG:   begin ts2 = pos_sat; mode2 = ssl_pkg::M_BANG; end
				C_EQ:     begin ts2 = pos_sat; mode2 = ssl_pkg::M_EQ; end
				C_LT:     begin ts2 = pos_sat; mode2 = ssl_pkg::M_LT; end
				C_GT:     begin ts2 = pos_sat; mode2 = ssl_pkg::M_GT; end
				C_SLASH:  begin ts2 = pos_sat; mode2 = ssl_pkg::M_SLASH; end
				C_QUOTE:  begin ts2 = pos_sat; mode2 = ssl_pkg::M_STRING; end
				C_NL: begin
					if (line_q != 16'hFFFF)
						line2 = line_q + 16'd1;
				end
				C_CR, C_SPACE, C_TAB: begin
				end
				default: begin
					if (is_digit) begin
						ts2   = pos_sat;
						mode2 = ssl_pkg::M_INT;
					end else if (is_alpha) begin
						ts2   = pos_sat;
						mode2 = ssl_pkg::M_IDENT;
					end else begin
						b_v    = 1'b1;
						b_kind = ssl_pkg::K_BAD;
					end
				end
			endcase
			if (b_v)
				ts2 = pos_sat;
		end

		// end of source flushes the pending token
		if (last_byte) begin
			unique case (mode2)
				ssl_pkg::M_BANG:    begin b_v = 1'b1; b_kind = ssl_pkg::K_BANG; end
				ssl_pkg::M_EQ:      begin b_v = 1'b1; b_kind = ssl_pkg::K_EQUAL; end
				ssl_pkg::M_LT:      begin b_v = 1'b1; b_kind = ssl_pkg::K_LESS; end
				ssl_pkg::M_GT:      begin b_v = 1'b1; b_kind = ssl_pkg::K_GREATER; end
				ssl_pkg::M_SLASH:   begin b_v = 1'b1; b_kind = ssl_pkg::K_SLASH; end
				ssl_pkg::M_STRING:  begin b_v = 1'b1; b_kind = ssl_pkg::K_UNTERM; end
				ssl_pkg::M_IDENT:   begin b_v = 1'b1; b_kind = kw_kind; end
				ssl_pkg::M_INT, ssl_pkg::M_FRAC: begin
					b_v    = 1'b1;
					b_kind = ssl_pkg::K_NUMBER;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		ssl_pkg::token_t ta;
		ssl_pkg::token_t tb;
		ta.kind  = a_kind;
		ta.start = tstart_q;
		ta.len   = ssl_pkg::tok_len(tstart_q, a_end);
		ta.line  = line_q;
		tb.kind  = b_kind;
		tb.start = ts2;
		tb.len   = ssl_pkg::tok_len(ts2, pos_p1);
		tb.line  = line_q;
		push.valid = acc && (a_v || b_v);
		if (a_v) begin
			push.pair.a     = ta;
			push.pair.b     = tb;
			push.pair.has_b = b_v;
		end else begin
			push.pair.a     = tb;
			push.pair.b     = tb;
			push.pair.has_b = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ssl_pkg::M_IDLE;
			tstart_q <= 16'd0;
			pos_q    <= 17'd0;
			line_q   <= ssl_pkg::FIRST_LINE_RST;
			plen_q   <= 3'd0;
		end else if (acc) begin
			if (last_byte) begin
				mode_q   <= ssl_pkg::M_IDLE;
				tstart_q <= 16'd0;
				pos_q    <= 17'd0;
				line_q   <= first_line;
				plen_q   <= 3'd0;
			end else begin
				mode_q   <= mode2;
				tstart_q <= ts2;
				line_q   <= line2;
				plen_q   <= plen_n;
				if (pos_q < POS_CAP)
					pos_q <= pos_q + 17'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			pfx_q <= pfx_n;
	end

endmodule

// File: hw/rtl/ssl_tok_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_tok_fifo
// two-entry queue of token pairs, drained one token per handshake
// ----------------------------------------------------------------------------
module ssl_tok_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  ssl_pkg::push_t  push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output ssl_pkg::token_t out_tok,
	output logic            out_last
);

	ssl_pkg::pair_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           sel_q;
	ssl_pkg::pair_t cur;
	logic           take;
	logic           pop;

	assign room      = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign cur       = mem_q[rd_q];
	assign out_tok   = sel_q ? cur.b : cur.a;
	assign out_last  = !cur.has_b || sel_q;
	assign take      = out_valid && out_ready;
	assign pop       = take && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
			sel_q <= 1'b0;
		end else begin
			if (push.valid)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (take)
				sel_q <= !out_last;
			cnt_q <= cnt_q + {1'b0, push.valid} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_q] <= push.pair;
	end

endmodule

// File: hw/rtl/ssl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_checker
// port-level checks on the lexer token stream
// ----------------------------------------------------------------------------
module ssl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [5:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled token holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("token changed while stalled");

	// kinds stay within the code space
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= 6'd39)
		else $error("token kind out of range");

	// lengths are never zero
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:16] != 16'd0)
		else $error("zero token length");

	// no token appears without a byte taken or a token already waiting
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(s_axis_tvalid && s_axis_tready) && !$past(m_axis_tvalid) |-> !m_axis_tvalid)
		else $error("token with no source byte");

endmodule

bind script_source_lexer ssl_checker u_ssl_checker (.*);

// File: tb/script_source_lexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_source_lexer_tb
// self-checking bench for the streaming tokenizer: source bytes are offered
// on the input stream, every accepted byte runs through a local scan model,
// and each token taken from the output stream is compared field by field
// with the oldest predicted token; directed rows first, then random sources
// ----------------------------------------------------------------------------
module script_source_lexer_tb;

	localparam int          WATCHDOG_CYCLES = 4000;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam logic [16:0] POS_LIMIT = (ssl_pkg::MAX_SOURCE_BYTES_DEF < 131071) ?
		17'(ssl_pkg::MAX_SOURCE_BYTES_DEF) : 17'd131071;

	// control bytes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	// one token as it should leave the block
	typedef struct {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic        last;
	} token_rec_t;

	// a token typed into the directed table, tied to the byte that causes it
	typedef struct {
		int         seq;
		token_rec_t tok;
	} pinned_t;

	// directed stimulus row; pinned rows carry their single expected token
	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic        pinned;
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [5:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	// bench control
	logic        calm = 1'b0;      // no idling on either side
	logic        hold_off = 1'b0;  // receiver refuses all tokens
	int          errors = 0;
	int          bytes_sent = 0;
	int          bytes_seen = 0;
	int          quiet_cycles = 0;

	token_rec_t  tokens_due [$];
	token_rec_t  byte_tokens [$];
	pinned_t     pinned_due [$];
	logic [7:0]  src_bytes [$];

	string kw_words [16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
		"or", "print", "return", "super", "this", "true", "var", "while"};

	// scan model state
	logic [3:0]  lex_mode = ssl_pkg::M_IDLE;
	logic [15:0] lex_start = 16'd0;
	logic [16:0] lex_pos = 17'd0;
	logic [15:0] lex_line = ssl_pkg::FIRST_LINE_RST;
	logic [15:0] first_line_reg = ssl_pkg::FIRST_LINE_RST;
	logic [7:0]  word_buf [6];
	logic [2:0]  word_len = 3'd0;

	// directed rows: extremes, bad bytes, a two-char operator, keyword,
	// number ending in a dot, comment, newline in and out of strings,
	// operator at the end, unterminated string, comment running to the end
	dir_row_t dir_rows [26] = '{
		'{"(",    1'b0, 1'b1, ssl_pkg::K_LPAREN, 16'd0, 16'd1, 16'd1},
		'{8'hFF,  1'b0, 1'b1, ssl_pkg::K_BAD,    16'd1, 16'd1, 16'd1},
		'{8'h00,  1'b0, 1'b1, ssl_pkg::K_BAD,    16'd2, 16'd1, 16'd1},
		'{"<",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"=",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{">",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"a",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"n",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"d",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{" ",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"1",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{".",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{";",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"/",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"/",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"x",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{CH_LF,  1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{CH_QUOTE, 1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{CH_LF,  1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{CH_QUOTE, 1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"=",    1'b1, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{CH_QUOTE, 1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"q",    1'b1, 1'b1, ssl_pkg::K_UNTERM, 16'd0, 16'd2, 16'd1},
		'{"/",    1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"/",    1'b1, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0},
		'{"!",    1'b1, 1'b1, ssl_pkg::K_BANG,   16'd0, 16'd1, 16'd1}
	};

	script_source_lexer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// single reset at the start of the run
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------------
	// scan model
	// ------------------------------------------------------------------------
	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// one-character kind of a pending comparison operator; +1 gives the
	// form with a trailing equals sign
	function automatic logic [5:0] op_kind(input logic [3:0] mode);
		case (mode)
		ssl_pkg::M_BANG: return ssl_pkg::K_BANG;
		ssl_pkg::M_EQ:   return ssl_pkg::K_EQUAL;
		ssl_pkg::M_LT:   return ssl_pkg::K_LESS;
		default: return ssl_pkg::K_GREATER;
		endcase
	endfunction

	// reserved word lookup; only the first word_len prefix bytes are looked at
	function automatic logic [5:0] word_kind();
		logic hit;
		if (word_len > 3'd6)
			return ssl_pkg::K_IDENT;
		for (int k = 0; k < 16; k++) begin
			if (kw_words[k].len() == int'(word_len)) begin
				hit = 1'b1;
				for (int i = 0; i < int'(word_len); i++)
					if (kw_words[k][i] != word_buf[i])
						hit = 1'b0;
				if (hit)
					return 6'(ssl_pkg::K_KEY0 + k);
			end
		end
		return ssl_pkg::K_IDENT;
	endfunction

	task automatic add_token(input logic [5:0] kind, input logic [17:0] end_p);
		logic [17:0] span;
		token_rec_t t;
		if (end_p > {2'b00, lex_start})
			span = end_p - {2'b00, lex_start};
		else
			span = 18'd1;
		if (span > 18'd65535)
			span = 18'd65535;
		t = '{kind, lex_start, span[15:0], lex_line, 1'b0};
		byte_tokens.insert(byte_tokens.size(), t);
	endtask

	task automatic open_token(input logic [16:0] pos, input logic [3:0] mode);
		lex_start = (pos > 17'd65535) ? 16'hFFFF : pos[15:0];
		lex_mode = mode;
	endtask

	// a byte seen from the idle mode
	task automatic scan_fresh(input logic [7:0] c, input logic [16:0] pos);
		int single;
		single = -1;
		case (c)
		"(": single = ssl_pkg::K_LPAREN;
		")": single = ssl_pkg::K_RPAREN;
		"{": single = ssl_pkg::K_LBRACE;
		"}": single = ssl_pkg::K_RBRACE;
		",": single = ssl_pkg::K_COMMA;
		".": single = ssl_pkg::K_DOT;
		"-": single = ssl_pkg::K_MINUS;
		"+": single = ssl_pkg::K_PLUS;
		";": single = ssl_pkg::K_SEMI;
		"*": single = ssl_pkg::K_STAR;
		"!": begin
			open_token(pos, ssl_pkg::M_BANG);
			return;
		end
		"=": begin
			open_token(pos, ssl_pkg::M_EQ);
			return;
		end
		"<": begin
			open_token(pos, ssl_pkg::M_LT);
			return;
		end
		">": begin
			open_token(pos, ssl_pkg::M_GT);
			return;
		end
		"/": begin
			open_token(pos, ssl_pkg::M_SLASH);
			return;
		end
		CH_QUOTE: begin
			open_token(pos, ssl_pkg::M_STRING);
			return;
		end
		CH_LF: begin
			if (lex_line != 16'hFFFF)
				lex_line = lex_line + 16'd1;
			return;
		end
		CH_CR, " ", CH_TAB: return;
		default: ;
		endcase
		if (single < 0) begin
			if (is_digit(c)) begin
				open_token(pos, ssl_pkg::M_INT);
				return;
			end
			if (is_alpha(c)) begin
				open_token(pos, ssl_pkg::M_IDENT);
				word_buf[0] = c;
				word_len = 3'd1;
				return;
			end
			single = ssl_pkg::K_BAD;
		end
		open_token(pos, ssl_pkg::M_IDLE);
		add_token(6'(single), 18'(pos) + 18'd1);
	endtask

	// advance the model by one accepted byte; tokens land in byte_tokens
	task automatic predict_byte(input logic [7:0] c, input logic last);
		logic [16:0] pos;
		logic rescan;
		pos = lex_pos;
		rescan = 1'b0;
		byte_tokens.delete();
		case (lex_mode)
		ssl_pkg::M_BANG, ssl_pkg::M_EQ, ssl_pkg::M_LT, ssl_pkg::M_GT: begin
			if (c == "=")
				add_token(op_kind(lex_mode) + 6'd1, 18'(pos) + 18'd1);
			else begin
				add_token(op_kind(lex_mode), 18'(pos));
				rescan = 1'b1;
			end
			lex_mode = ssl_pkg::M_IDLE;
		end
		ssl_pkg::M_SLASH: begin
			if (c == "/")
				lex_mode = ssl_pkg::M_COMMENT;
			else begin
				add_token(ssl_pkg::K_SLASH, 18'(pos));
				lex_mode = ssl_pkg::M_IDLE;
				rescan = 1'b1;
			end
		end
		ssl_pkg::M_COMMENT: begin
			// the closing newline is rescanned so that it still counts a line
			if (c == CH_LF) begin
				lex_mode = ssl_pkg::M_IDLE;
				rescan = 1'b1;
			end
		end
		ssl_pkg::M_STRING: begin
			if (c == CH_QUOTE) begin
				add_token(ssl_pkg::K_STRING, 18'(pos) + 18'd1);
				lex_mode = ssl_pkg::M_IDLE;
			end
		end
		ssl_pkg::M_IDENT: begin
			if (is_alpha(c)) begin
				if (word_len < 3'd6)
					word_buf[word_len] = c;
				if (word_len < 3'd7)
					word_len = word_len + 3'd1;
			end else begin
				add_token(word_kind(), 18'(pos));
				lex_mode = ssl_pkg::M_IDLE;
				rescan = 1'b1;
			end
		end
		ssl_pkg::M_INT: begin
			if (c == ".")
				lex_mode = ssl_pkg::M_FRAC;
			else if (!is_digit(c)) begin
				add_token(ssl_pkg::K_NUMBER, 18'(pos));
				lex_mode = ssl_pkg::M_IDLE;
				rescan = 1'b1;
			end
		end
		ssl_pkg::M_FRAC: begin
			if (!is_digit(c)) begin
				add_token(ssl_pkg::K_NUMBER, 18'(pos));
				lex_mode = ssl_pkg::M_IDLE;
				rescan = 1'b1;
			end
		end
		default: begin
			lex_mode = ssl_pkg::M_IDLE;
			rescan = 1'b1;
		end
		endcase
		if (rescan)
			scan_fresh(c, pos);

		if (last) begin
			// flush whatever is pending and restart for a new source
			case (lex_mode)
			ssl_pkg::M_BANG, ssl_pkg::M_EQ, ssl_pkg::M_LT, ssl_pkg::M_GT:
				add_token(op_kind(lex_mode), 18'(pos) + 18'd1);
			ssl_pkg::M_SLASH:  add_token(ssl_pkg::K_SLASH, 18'(pos) + 18'd1);
			ssl_pkg::M_STRING: add_token(ssl_pkg::K_UNTERM, 18'(pos) + 18'd1);
			ssl_pkg::M_IDENT:  add_token(word_kind(), 18'(pos) + 18'd1);
			ssl_pkg::M_INT, ssl_pkg::M_FRAC:
				add_token(ssl_pkg::K_NUMBER, 18'(pos) + 18'd1);
			default: ;
			endcase
			lex_mode = ssl_pkg::M_IDLE;
			lex_start = 16'd0;
			lex_pos = 17'd0;
			lex_line = first_line_reg;
			word_len = 3'd0;
		end else if (lex_pos < POS_LIMIT) begin
			lex_pos = lex_pos + 17'd1;
		end

		if (byte_tokens.size() != 0)
			byte_tokens[byte_tokens.size() - 1].last = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// input and config acceptance feed the model, output acceptance is checked
	always @(posedge clk) begin : token_check
		token_rec_t want;
		pinned_t    pin;
		logic       moved;
		int         idx;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				first_line_reg = cfg_data;
				moved = 1'b1;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				idx = bytes_seen;
				bytes_seen++;
				predict_byte(s_axis_tdata, s_axis_tlast);
				// a pinned row replaces the model's tokens by the typed one
				if (pinned_due.size() != 0 && pinned_due[0].seq == idx) begin
					pin = pinned_due.pop_front();
					tokens_due.insert(tokens_due.size(), pin.tok);
				end else begin
					foreach (byte_tokens[i])
						tokens_due.insert(tokens_due.size(), byte_tokens[i]);
				end
				moved = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				if (tokens_due.size() == 0) begin
					$error("token with nothing expected: kind %0d start %0d",
						m_axis_tuser, m_axis_tdata[15:0]);
					errors++;
				end else begin
					want = tokens_due.pop_front();
					check_field("token_kind", want.kind, m_axis_tuser);
					check_field("start_pos", want.start, m_axis_tdata[15:0]);
					check_field("token_len", want.len, m_axis_tdata[31:16]);
					check_field("line_num", want.line, m_axis_tdata[47:32]);
					check_field("last_of_run", want.last, m_axis_tlast);
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	// a stall of the whole flow ends the run
	initial begin
		wait (quiet_cycles >= WATCHDOG_CYCLES);
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// receiver: random stalls, none while calm, a stall throughout while held off
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_off)
			m_axis_tready <= 1'b0;
		else if (calm)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= 21);
	end

	// one long refusal in mid run so that the pair queue fills and the
	// input side backs up while the sender keeps offering bytes
	initial begin
		wait (bytes_seen >= 420);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ------------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] c, input logic last);
		while (!calm && $urandom_range(0, 99) < 21) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// first_line is only written once every token has come out
	task automatic write_first_line(input logic [15:0] value);
		s_axis_tvalid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		// a byte with no token may still be in the scan stage
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 3) == 0)
			return 8'("A" + $urandom_range(0, 25));
		return 8'("a" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	// append one byte to the source being built
	task automatic put_byte(input logic [7:0] c);
		src_bytes.insert(src_bytes.size(), c);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	// append one lexeme, well formed most of the time
	task automatic add_lexeme();
		string s;
		logic [7:0] c;
		case ($urandom_range(0, 11))
		0: add_text(kw_words[$urandom_range(0, 15)]);
		1: begin
			// keyword prefix, possibly grown past the keyword
			s = kw_words[$urandom_range(0, 15)];
			add_text(s.substr(0, $urandom_range(0, s.len() - 1)));
			repeat ($urandom_range(0, 4)) put_byte(rand_letter());
		end
		2: repeat ($urandom_range(1, 9)) put_byte(rand_letter());
		3: begin
			repeat ($urandom_range(1, 4)) put_byte(rand_digit());
			if ($urandom_range(0, 1) == 1) begin
				put_byte(".");
				repeat ($urandom_range(0, 3)) put_byte(rand_digit());
			end
		end
		4: begin
			put_byte(CH_QUOTE);
			repeat ($urandom_range(0, 8)) begin
				case ($urandom_range(0, 3))
				0: c = rand_letter();
				1: c = CH_LF;
				2: c = " ";
				default: begin
					c = 8'($urandom_range(0, 255));
					if (c == CH_QUOTE)
						c = "#";
				end
				endcase
				put_byte(c);
			end
			if ($urandom_range(0, 9) != 0)
				put_byte(CH_QUOTE);
		end
		5: begin
			add_text("//");
			repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) != 0)
				put_byte(CH_LF);
		end
		6: begin
			s = "(){},.-+;*/";
			put_byte(s[$urandom_range(0, s.len() - 1)]);
		end
		7: begin
			s = "!=<>";
			put_byte(s[$urandom_range(0, 3)]);
			if ($urandom_range(0, 4) < 3)
				put_byte("=");
		end
		8: begin
			case ($urandom_range(0, 3))
			0: put_byte(" ");
			1: put_byte(CH_TAB);
			2: put_byte(CH_CR);
			default: put_byte(CH_LF);
			endcase
		end
		9: put_byte(8'($urandom_range(0, 255)));
		10: put_byte("/");
		default: put_byte(CH_LF);
		endcase
	endtask

	// short random sources; now and then the end flag is dropped or lands
	// in the middle of a lexeme
	task automatic random_sources(input int quota);
		int sent;
		logic flag;
		sent = 0;
		while (sent < quota) begin
			src_bytes.delete();
			repeat ($urandom_range(1, 10)) begin
				add_lexeme();
				if ($urandom_range(0, 2) == 0)
					put_byte(" ");
			end
			foreach (src_bytes[i]) begin
				if (i == src_bytes.size() - 1)
					flag = ($urandom_range(0, 19) != 0);
				else
					flag = ($urandom_range(0, 199) == 0);
				send_byte(src_bytes[i], flag);
			end
			sent += src_bytes.size();
		end
	endtask

	// ------------------------------------------------------------------------
	// run
	// ------------------------------------------------------------------------
	initial begin : run
		pinned_t pin;
		wait (arst_n);
		@(posedge clk);

		// directed table with first_line still at its reset value
		foreach (dir_rows[i]) begin
			if (dir_rows[i].pinned) begin
				pin.seq = bytes_sent;
				pin.tok = '{dir_rows[i].kind, dir_rows[i].start, dir_rows[i].len,
					dir_rows[i].line, 1'b1};
				pinned_due.insert(pinned_due.size(), pin);
			end
			send_byte(dir_rows[i].ch, dir_rows[i].last);
		end

		// top line value: newlines must saturate
		write_first_line(16'hFFFF);
		random_sources(140);

		// bottom line value, with a stretch of no idling on either side
		write_first_line(16'h0000);
		calm <= 1'b1;
		random_sources(140);
		calm <= 1'b0;

		// random line value; the long receiver hold-off falls in here
		write_first_line(16'($urandom_range(0, 65535)));
		random_sources(140);

		write_first_line(16'($urandom_range(0, 65535)));
		random_sources(140);

		s_axis_tvalid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
